@@ rtl/core/afp_pkg.sv @@
// Shared constants for the accelerometer frame parser.
package afp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ACCEL_W = 15;
   localparam int unsigned ACCUM_W = 7;
   localparam int unsigned MAG_W   = 14;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned CNT_W   = 2;
   localparam int unsigned AXES    = 3;
   localparam int unsigned AXIS_W  = 2;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(17);
   localparam logic [POS_W-1:0] POS_SAT  = POS_W'(19);

   localparam logic [BYTE_W-1:0] CHAR_TERM  = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam int ACCEL_LIMIT = 9999;

endpackage

@@ rtl/core/accel_frame_parser_unit.sv @@
// Accelerometer frame parser: ASCII frame bytes in, three signed axis values out.
//
// Input channel (req_*): one frame byte per transaction, req_last marks the
// final byte. A frame is 18 bytes: two ignored bytes, then X, Y and Z fields
// of sign, two integer digits and two fraction digits, then ';'. Non-digit
// bytes inside a digit field are skipped.
// Result channel (rsp_*): one transaction per frame, issued for the byte
// carrying req_last. Values are in hundredths; rsp_format_error is set, and
// the values are zero, on a wrong length, wrong terminator or an axis with
// no digits.
// Path: the last byte goes through the input register, then the result
// register, where rsp_valid rises. Throughput: one byte per cycle while no
// byte carrying req_last waits on a stalled result; the per-byte update is
// a single pass of digit accumulate and axis scaling.
// Reset: synchronous; clears both pipeline stages and all frame state, so
// the next byte is taken as position 0 of a new frame.
// Stall: a result waiting on rsp_ready holds back only a byte carrying
// req_last; that byte stays in the input register and req_ready drops until
// the result is taken. Other bytes keep flowing; nothing is lost or repeated.
module accel_frame_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [afp_pkg::BYTE_W-1:0]           req_frame_byte,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [afp_pkg::ACCEL_W-1:0]   rsp_accel_x,
   output logic signed [afp_pkg::ACCEL_W-1:0]   rsp_accel_y,
   output logic signed [afp_pkg::ACCEL_W-1:0]   rsp_accel_z,
   output logic                                 rsp_format_error
);
   import afp_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_SIGN, PH_INT, PH_FRAC} phase_type;

   // input register
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;

   // frame state
   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic               neg_ff,   neg_in;
   logic [ACCUM_W-1:0] int_ff,   int_in;
   logic [ACCUM_W-1:0] frac_ff,  frac_in;
   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic               seen_ff,  seen_in;
   logic               empty_ff, empty_in;
   logic [ACCEL_W-1:0] axis_ff [AXES];
   logic [ACCEL_W-1:0] axis_in [AXES];

   // result register
   logic               rsp_valid_ff;
   logic [ACCEL_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic               rsp_err_ff;

   logic                stall;
   logic                advance;
   logic                is_digit;
   logic [3:0]          digit;
   phase_type           phase;
   logic                finish;
   logic [AXIS_W-1:0]   axis_idx;
   logic [10:0]         int_mac;
   logic [10:0]         frac_mac;
   logic [MAG_W-1:0]    frac_part;
   logic [MAG_W-1:0]    mag;
   logic [ACCEL_W-1:0]  axis_val;
   logic                frame_ok;

   // only a last byte needs the result register
   assign stall     = rsp_valid_ff && !rsp_ready;
   assign advance   = s1_valid_ff && !(s1_last_ff && stall);
   assign req_ready = !s1_valid_ff || advance;

   // position decode: which field of which axis this byte belongs to
   always_comb begin
      case (pos_ff) inside
         5'd2, 5'd7, 5'd12:                    phase = PH_SIGN;
         5'd3, 5'd4, 5'd8, 5'd9, 5'd13, 5'd14:  phase = PH_INT;
         5'd5, 5'd6, 5'd10, 5'd11, 5'd15, 5'd16: phase = PH_FRAC;
         default:                              phase = PH_IDLE;
      endcase
      case (pos_ff) inside
         [5'd2:5'd6]:   axis_idx = AXIS_W'(0);
         [5'd7:5'd11]:  axis_idx = AXIS_W'(1);
         default:       axis_idx = AXIS_W'(2);
      endcase
      finish = (pos_ff == POS_W'(6)) || (pos_ff == POS_W'(11)) || (pos_ff == POS_W'(16));
   end

   assign is_digit = (s1_byte_ff >= CHAR_ZERO) && (s1_byte_ff <= CHAR_NINE);
   assign digit    = is_digit ? s1_byte_ff[3:0] : 4'd0;
   assign int_mac  = 11'(int_ff) * 11'd10 + 11'(digit);
   assign frac_mac = 11'(frac_ff) * 11'd10 + 11'(digit);

   assign frame_ok = (pos_ff == POS_LAST) && (s1_byte_ff == CHAR_TERM) && !empty_ff;

   always_comb begin
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      seen_in  = seen_ff;
      empty_in = empty_ff;
      for (int i = 0; i < AXES; i++) begin
         axis_in[i] = axis_ff[i];
      end

      case (phase)
         PH_SIGN: begin
            neg_in  = (s1_byte_ff == CHAR_MINUS);
            int_in  = '0;
            frac_in = '0;
            cnt_in  = '0;
            seen_in = 1'b0;
         end
         PH_INT: begin
            if (is_digit) begin
               int_in  = int_mac[ACCUM_W-1:0];
               seen_in = 1'b1;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               frac_in = frac_mac[ACCUM_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
               seen_in = 1'b1;
            end
         end
         default: ;
      endcase

      // axis value in hundredths from the updated accumulators
      case (cnt_in)
         2'd2:    frac_part = MAG_W'(frac_in);
         2'd1:    frac_part = MAG_W'(frac_in) * MAG_W'(10);
         default: frac_part = '0;
      endcase
      mag      = MAG_W'(int_in) * MAG_W'(100) + frac_part;
      axis_val = neg_in ? (ACCEL_W'(0) - ACCEL_W'(mag)) : ACCEL_W'(mag);

      if (finish) begin
         axis_in[axis_idx] = axis_val;
         if (!seen_in) begin
            empty_in = 1'b1;
         end
      end

      if (s1_last_ff) begin
         // frame done: back to the start-of-frame state
         pos_in   = '0;
         neg_in   = 1'b0;
         int_in   = '0;
         frac_in  = '0;
         cnt_in   = '0;
         seen_in  = 1'b0;
         empty_in = 1'b0;
         for (int i = 0; i < AXES; i++) begin
            axis_in[i] = '0;
         end
      end else if (pos_ff < POS_SAT) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         neg_ff       <= 1'b0;
         int_ff       <= '0;
         frac_ff      <= '0;
         cnt_ff       <= '0;
         seen_ff      <= 1'b0;
         empty_ff     <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            axis_ff[i] <= '0;
         end
      end else begin
         // input stage
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
            s1_byte_ff  <= req_frame_byte;
            s1_last_ff  <= req_last;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         // frame state update, one byte per cycle unless a last byte is stalled
         if (advance) begin
            pos_ff   <= pos_in;
            neg_ff   <= neg_in;
            int_ff   <= int_in;
            frac_ff  <= frac_in;
            cnt_ff   <= cnt_in;
            seen_ff  <= seen_in;
            empty_ff <= empty_in;
            for (int i = 0; i < AXES; i++) begin
               axis_ff[i] <= axis_in[i];
            end
         end

         // result stage
         if (advance && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_err_ff   <= !frame_ok;
            rsp_x_ff     <= frame_ok ? axis_ff[0] : '0;
            rsp_y_ff     <= frame_ok ? axis_ff[1] : '0;
            rsp_z_ff     <= frame_ok ? axis_ff[2] : '0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accel_x      = rsp_x_ff;
   assign rsp_accel_y      = rsp_y_ff;
   assign rsp_accel_z      = rsp_z_ff;
   assign rsp_format_error = rsp_err_ff;

endmodule

@@ rtl/core/afp_checker.sv @@
// Port-level checks for the accelerometer frame parser, bound to the top level.
module afp_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [afp_pkg::BYTE_W-1:0]           req_frame_byte,
   input  logic                                 req_last,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [afp_pkg::ACCEL_W-1:0]   rsp_accel_x,
   input  logic signed [afp_pkg::ACCEL_W-1:0]   rsp_accel_y,
   input  logic signed [afp_pkg::ACCEL_W-1:0]   rsp_accel_z,
   input  logic                                 rsp_format_error
);
   import afp_pkg::*;

   logic req_seen;
   assign req_seen = req_valid || req_ready || req_last || (req_frame_byte != '0);

   // a reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an error result carries zero values
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_format_error) |->
         (rsp_accel_x == '0 && rsp_accel_y == '0 && rsp_accel_z == '0))
      else $error("error result with non-zero values");

   // values stay within the representable frame range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_accel_x >= -ACCEL_LIMIT && rsp_accel_x <= ACCEL_LIMIT &&
          rsp_accel_y >= -ACCEL_LIMIT && rsp_accel_y <= ACCEL_LIMIT &&
          rsp_accel_z >= -ACCEL_LIMIT && rsp_accel_z <= ACCEL_LIMIT))
      else $error("axis value out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset || req_seen === 1'bx)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_accel_x) && $stable(rsp_accel_y) &&
          $stable(rsp_accel_z) && $stable(rsp_format_error)))
      else $error("stalled result changed");

endmodule

bind accel_frame_parser_unit afp_checker u_afp_checker (.*);

@@ tb/accel_frame_parser_checker.sv @@
// Predicts accelerometer frame results from accepted bytes and checks each result transaction.
`timescale 1ns / 1ps

module accel_frame_parser_checker
   import afp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [BYTE_W-1:0]          req_frame_byte,
   input  logic                       req_last,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [ACCEL_W-1:0]  rsp_accel_x,
   input  logic signed [ACCEL_W-1:0]  rsp_accel_y,
   input  logic signed [ACCEL_W-1:0]  rsp_accel_z,
   input  logic                       rsp_format_error,
   output int                         mismatch_count,
   output int                         frames_outstanding,
   output int                         frames_checked,
   output int                         frames_flagged
);

   // field layout: sign, two integer digits, two fraction digits
   localparam int unsigned FIELD_FIRST   = 2;
   localparam int unsigned FIELD_LAST    = 16;
   localparam int unsigned FIELD_LEN     = 5;
   localparam int unsigned SIGN_OFF      = 0;
   localparam int unsigned INT_LAST_OFF  = 2;
   localparam int unsigned FRAC_LAST_OFF = 4;

   typedef struct {
      logic signed [ACCEL_W-1:0] x;
      logic signed [ACCEL_W-1:0] y;
      logic signed [ACCEL_W-1:0] z;
      logic                      err;
   } axes_type;

   axes_type expected_axes_q[$];

   logic [POS_W-1:0]   pos_r;
   logic               neg_r;
   logic [ACCUM_W-1:0] int_r;
   logic [ACCUM_W-1:0] frac_r;
   logic [CNT_W-1:0]   frac_cnt_r;
   logic               seen_r;
   logic [ACCEL_W-1:0] axis_r [AXES];
   logic               empty_r;

   function automatic void clear_frame();
      pos_r      = '0;
      neg_r      = 1'b0;
      int_r      = '0;
      frac_r     = '0;
      frac_cnt_r = '0;
      seen_r     = 1'b0;
      for (int i = 0; i < AXES; i++) axis_r[i] = '0;
      empty_r    = 1'b0;
   endfunction

   function automatic void parse_frame_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      int unsigned p;
      int unsigned off;
      int unsigned ax;
      int unsigned mag;
      int unsigned d;
      logic        digit;
      axes_type    res;
      p     = pos_r;
      digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      d     = b - CHAR_ZERO;
      if (p >= FIELD_FIRST && p <= FIELD_LAST) begin
         ax  = (p - FIELD_FIRST) / FIELD_LEN;
         off = (p - FIELD_FIRST) % FIELD_LEN;
         if (off == SIGN_OFF) begin
            neg_r      = (b == CHAR_MINUS);
            int_r      = '0;
            frac_r     = '0;
            frac_cnt_r = '0;
            seen_r     = 1'b0;
         end else if (off <= INT_LAST_OFF) begin
            if (digit) begin
               int_r  = ACCUM_W'(int_r * 10 + d);
               seen_r = 1'b1;
            end
         end else if (digit) begin
            frac_r     = ACCUM_W'(frac_r * 10 + d);
            frac_cnt_r = frac_cnt_r + 1'b1;
            seen_r     = 1'b1;
         end
         if (off == FRAC_LAST_OFF) begin
            mag = int_r * 100;
            if (frac_cnt_r == 2) mag += frac_r;
            else if (frac_cnt_r == 1) mag += frac_r * 10;
            if (neg_r) mag = 0 - mag;
            axis_r[ax] = ACCEL_W'(mag);
            if (!seen_r) empty_r = 1'b1;
         end
      end
      if (!is_last) begin
         if (pos_r < POS_SAT) pos_r = pos_r + 1'b1;
      end else begin
         if (p == POS_LAST && b == CHAR_TERM && !empty_r) begin
            res.x   = axis_r[0];
            res.y   = axis_r[1];
            res.z   = axis_r[2];
            res.err = 1'b0;
         end else begin
            res.x   = '0;
            res.y   = '0;
            res.z   = '0;
            res.err = 1'b1;
            frames_flagged++;
         end
         expected_axes_q.push_back(res);
         clear_frame();
      end
   endfunction

   initial begin
      mismatch_count = 0;
      frames_checked = 0;
      frames_flagged = 0;
      frames_outstanding = 0;
      clear_frame();
   end

   always @(posedge clock) begin
      axes_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_axes_q.size() == 0) begin
               $error("result transaction with no frame outstanding");
               mismatch_count++;
            end else begin
               want = expected_axes_q.pop_front();
               frames_checked++;
               if (rsp_accel_x !== want.x) begin
                  $error("accel_x: expected %0d, got %0d", want.x, rsp_accel_x);
                  mismatch_count++;
               end
               if (rsp_accel_y !== want.y) begin
                  $error("accel_y: expected %0d, got %0d", want.y, rsp_accel_y);
                  mismatch_count++;
               end
               if (rsp_accel_z !== want.z) begin
                  $error("accel_z: expected %0d, got %0d", want.z, rsp_accel_z);
                  mismatch_count++;
               end
               if (rsp_format_error !== want.err) begin
                  $error("format_error: expected %0b, got %0b", want.err, rsp_format_error);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) parse_frame_byte(req_frame_byte, req_last);
         frames_outstanding <= expected_axes_q.size();
      end
   end

endmodule

@@ tb/accel_frame_parser_unit_tb.sv @@
// Top of the accelerometer frame parser testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module accel_frame_parser_unit_tb;
   import afp_pkg::*;

   localparam int CLK_HALF         = 5;
   localparam int RESET_CYCLES     = 5;
   localparam int MAX_GAP          = 4;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int BURST_FRAMES     = 25;
   localparam int DRAIN_CYCLES     = 10;
   localparam int TARGET_BYTES     = 1800;
   localparam int HOLD_AT_FRAME    = 30;
   localparam int PAUSE_AT_FRAME   = 60;
   localparam int TIMEOUT_NS       = 3_000_000;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_TERM,
      FRAME_EMPTY_AXIS,
      FRAME_SHORT,
      FRAME_LONG,
      FRAME_NOISE
   } frame_kind_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [BYTE_W-1:0]          req_frame_byte;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [ACCEL_W-1:0]  rsp_accel_x;
   logic signed [ACCEL_W-1:0]  rsp_accel_y;
   logic signed [ACCEL_W-1:0]  rsp_accel_z;
   logic                       rsp_format_error;

   int mismatch_count;
   int frames_outstanding;
   int frames_checked;
   int frames_flagged;

   logic [BYTE_W-1:0] frame_bytes[$];
   int                bytes_sent;
   int                frames_sent;
   bit                sender_calm;
   bit                receiver_calm;
   bit                long_hold_request;

   // Directed frames, which exercise:
   //  full-scale values with extreme header bytes, negative zero,
   //  fraction-only and single-fraction-digit axes, integer-only axes,
   //  an axis with no digits, a wrong terminator, a short frame,
   //  an overlong frame past saturation, a one-byte frame, plain good frames.
   string directed_frames [11] = '{
      "AB+9999-9999+0000;",
      "AB-0000-0000-0000;",
      "AB+ab12+1a5b-x7y3;",
      "AB+12ab-9.9.+34  ;",
      "AB+abcd+1111+2222;",
      "AB+1111+2222+3333:",
      "AB+1111+22",
      "AB+0101+0202+0303;XYZW123",
      "Q",
      "AB+0101+0202+0303;",
      "zz-1234+5678-9012;"
   };

   accel_frame_parser_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_byte   (req_frame_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accel_x      (rsp_accel_x),
      .rsp_accel_y      (rsp_accel_y),
      .rsp_accel_z      (rsp_accel_z),
      .rsp_format_error (rsp_format_error)
   );

   accel_frame_parser_checker chk (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frame_byte     (req_frame_byte),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accel_x        (rsp_accel_x),
      .rsp_accel_y        (rsp_accel_y),
      .rsp_accel_z        (rsp_accel_z),
      .rsp_format_error   (rsp_format_error),
      .mismatch_count     (mismatch_count),
      .frames_outstanding (frames_outstanding),
      .frames_checked     (frames_checked),
      .frames_flagged     (frames_flagged)
   );

   initial clock = 1'b0;
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // --- byte helpers ------------------------------------------------------

   function automatic logic [BYTE_W-1:0] any_non_digit();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255));
      while (b >= CHAR_ZERO && b <= CHAR_NINE);
      return b;
   endfunction

   // mostly a digit, now and then a byte the parser skips
   function automatic logic [BYTE_W-1:0] digit_slot();
      if ($urandom_range(0, 9) != 0) return CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
      return any_non_digit();
   endfunction

   function automatic logic [BYTE_W-1:0] sign_slot();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return CHAR_MINUS;
      if (r < 90) return "+";
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic load_text(input string s);
      frame_bytes.delete();
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endtask

   // Mostly well-formed frames with random content; the rest are broken on purpose.
   task automatic build_frame(input frame_kind_type kind);
      int                empty_ax;
      int                keep;
      logic [BYTE_W-1:0] b;
      frame_bytes.delete();
      empty_ax = $urandom_range(0, AXES - 1);
      frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      for (int ax = 0; ax < AXES; ax++) begin
         frame_bytes.push_back(sign_slot());
         for (int k = 0; k < 4; k++) begin
            if (kind == FRAME_EMPTY_AXIS && ax == empty_ax) frame_bytes.push_back(any_non_digit());
            else frame_bytes.push_back(digit_slot());
         end
      end
      if (kind == FRAME_BAD_TERM) begin
         do b = BYTE_W'($urandom_range(0, 255));
         while (b == CHAR_TERM);
         frame_bytes.push_back(b);
      end else begin
         frame_bytes.push_back(CHAR_TERM);
      end
      case (kind)
         FRAME_SHORT: begin
            keep = $urandom_range(1, POS_LAST);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
         end
         FRAME_LONG: begin
            // past the end; with two or more extra bytes the position count saturates
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
         end
         FRAME_NOISE: begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 30)) frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   // --- request side ------------------------------------------------------

   // Valid rises on its own and holds, payload steady, until the accepting edge.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= b;
      req_last       <= is_last;
      do @(posedge clock);
      while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      sender_calm = ($urandom_range(0, 9) == 0);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   // Hold the request side until every predicted result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int r;
      req_valid         = 1'b0;
      req_frame_byte    = '0;
      req_last          = 1'b0;
      reset             = 1'b1;
      bytes_sent        = 0;
      frames_sent       = 0;
      sender_calm       = 1'b0;
      long_hold_request = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      foreach (directed_frames[i]) begin
         load_text(directed_frames[i]);
         if (i == 0) begin
            frame_bytes[0] = 8'h00;
            frame_bytes[1] = 8'hFF;
         end
         send_frame();
      end

      // random frames
      while (bytes_sent < TARGET_BYTES) begin
         if (frames_sent == HOLD_AT_FRAME) begin
            // receiver freezes for a long spell while one-byte frames keep
            // coming, so both stages fill and req_ready drops
            long_hold_request = 1'b1;
            repeat (BURST_FRAMES) begin
               frame_bytes.delete();
               frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
               send_frame();
            end
         end
         if (frames_sent == PAUSE_AT_FRAME) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 65)      build_frame(FRAME_GOOD);
         else if (r < 73) build_frame(FRAME_BAD_TERM);
         else if (r < 81) build_frame(FRAME_EMPTY_AXIS);
         else if (r < 88) build_frame(FRAME_SHORT);
         else if (r < 95) build_frame(FRAME_LONG);
         else             build_frame(FRAME_NOISE);
         send_frame();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d frames; %0d results checked, %0d of them format errors.",
               bytes_sent, frames_sent, frames_checked, frames_flagged);
      $display("Run included a %0d-cycle result back-pressure spell and a full drain pause.",
               LONG_HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // --- result side -------------------------------------------------------

   initial begin
      int stall;
      rsp_ready     = 1'b0;
      receiver_calm = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock);
         while (!rsp_valid);
         // occasional spells with no stalling
         if ($urandom_range(0, 19) == 0) receiver_calm = !receiver_calm;
      end
   end

   // watchdog
   initial begin
      #TIMEOUT_NS;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
